// ----- design/rnv21_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnv21_pkg
// Shared types, constants and helpers for the RGB to NV21 rotating converter.
// ----------------------------------------------------------------------------
package rnv21_pkg;

  localparam int MAX_DIM  = 4096;
  localparam int DIM_W    = 13;               // register width for a dimension
  localparam int CNT_W    = 12;               // source column / row counters
  localparam int LADDR_W  = 24;
  localparam int CADDR_W  = 25;
  localparam int FSIZE_W  = 25;               // W*H, up to MAX_DIM squared

  localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);
  localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);
  localparam logic [FSIZE_W-1:0] FSIZE_RST = FSIZE_W'(640 * 480);

  localparam logic [7:0] LUMA_OFS   = 8'd16;
  localparam logic [7:0] CHROMA_OFS = 8'd128;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_FLIP   = 2'd2,
    REG_NONE   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pix_t;

  typedef struct packed {
    logic [LADDR_W-1:0] luma_address;
    logic [7:0]         luma_value;
    logic               chroma_valid;
    logic [CADDR_W-1:0] chroma_address;
    logic [7:0]         v_value;
    logic [7:0]         u_value;
    logic               frame_end;
  } nv21_res_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] v;
    logic [7:0] u;
  } yuv_t;

  // Dimension register as used: held within [2, MAX_DIM].
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] res;
    if (d < DIM_MIN) begin
      res = DIM_MIN;
    end else if (d > DIM_MAX) begin
      res = DIM_MAX;
    end else begin
      res = d;
    end
    return res;
  endfunction

endpackage

// ----- design/rnv21_color.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnv21_color
// Shift-and-add RGB to YUV conversion, one pixel, combinational.
// ----------------------------------------------------------------------------
module rnv21_color import rnv21_pkg::*; (
  input  rgb_pix_t pix,
  output yuv_t     yuv
);

  // 10-bit modular sums; only the low byte is kept.
  logic [9:0] r, g, b;
  logic [9:0] y_sum, v_sum, u_sum;

  assign r = {2'b00, pix.red};
  assign g = {2'b00, pix.green};
  assign b = {2'b00, pix.blue};

  // g>>8 and b>>8 are always zero for 8-bit inputs.
  assign y_sum = (r >> 2) + (r >> 7) + (g >> 1) + (b >> 4) + (b >> 5)
               + {2'b00, LUMA_OFS};
  assign v_sum = (r >> 1) - (r >> 4) - (g >> 2) - (g >> 3) + (g >> 7)
               - (b >> 4) - (b >> 7) + {2'b00, CHROMA_OFS};
  assign u_sum = (b >> 1) - (b >> 4) - (r >> 3) - (r >> 6) - (r >> 7)
               - (g >> 2) - (g >> 5) - (g >> 7) + {2'b00, CHROMA_OFS};

  assign yuv.y = y_sum[7:0];
  assign yuv.v = v_sum[7:0];
  assign yuv.u = u_sum[7:0];

endmodule

// ----- design/rgb_to_nv21_rotating_converter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_nv21_rotating_converter
// RGB pixel stream to NV21 bytes, rotated 90 degrees clockwise, optional flip.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one source RGB pixel per request, source raster order.
//   out_* : one result per pixel: luma byte and its address, plus the V/U
//           pair and its interleaved chroma address when both output
//           coordinates are even (chroma fields zero otherwise).
//   APB   : register 0 source width, 1 source height, 2 flip enable, at byte
//           offsets 0, 4, 8. Writing width or height restarts the frame.
// Pipeline: input register, then result register. Throughput: one pixel per
//   cycle while out_stall is low; each stage is a single register with all
//   of its work done in one pass, so nothing iterates.
// Stall: the result register holds while it is valid and out_stall is high;
//   an empty input register still takes one more pixel, after which in_stall follows.
// Reset: counters clear, width 640, height 480, flip off, both stages empty.
// ----------------------------------------------------------------------------
module rgb_to_nv21_rotating_converter import rnv21_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // pixel input
  input  logic        in_valid,
  output logic        in_stall,
  input  rgb_pix_t    in_data,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output nv21_res_t   out_data,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]   width_r, height_r;
  logic               flip_r;
  logic [FSIZE_W-1:0] fsize_r;          // clamped W*H, chroma plane base
  logic               cfg_wr;
  cfg_reg_t           cfg_idx;
  logic [DIM_W-1:0]   wr_dim;
  logic [DIM_W-1:0]   fs_w, fs_h;
  logic [2*DIM_W-1:0] fs_prod;
  logic               restart;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_t'(paddr[3:2]);
  assign wr_dim  = pwdata[DIM_W-1:0];
  assign restart = cfg_wr && ((cfg_idx == REG_WIDTH) || (cfg_idx == REG_HEIGHT));

  // Frame size follows the new dimension, so it is ready for the next pixel.
  always_comb begin
    fs_w = clamp_dim(width_r);
    fs_h = clamp_dim(height_r);
    if (cfg_wr && cfg_idx == REG_WIDTH) begin
      fs_w = clamp_dim(wr_dim);
    end
    if (cfg_wr && cfg_idx == REG_HEIGHT) begin
      fs_h = clamp_dim(wr_dim);
    end
  end
  assign fs_prod = {{DIM_W{1'b0}}, fs_w} * {{DIM_W{1'b0}}, fs_h};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      flip_r   <= 1'b0;
      fsize_r  <= FSIZE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  width_r  <= wr_dim;
        REG_HEIGHT: height_r <= wr_dim;
        REG_FLIP:   flip_r   <= pwdata[0];
        default:    ;
      endcase
      fsize_r <= fs_prod[FSIZE_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, width_r};
      REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, height_r};
      REG_FLIP:   prdata = {31'd0, flip_r};
      default:    prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Source position and output coordinates (computed at accept)
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [CNT_W-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [CNT_W-1:0] col_c, row_c;       // counters held below the dimension
  logic [DIM_W-1:0] w_m1, h_m1;
  logic [DIM_W-1:0] ox_full, oy_full, col_inc, row_inc;
  logic             last_c;
  logic             in_acc;

  assign w_eff = clamp_dim(width_r);
  assign h_eff = clamp_dim(height_r);
  assign w_m1  = w_eff - DIM_W'(1);
  assign h_m1  = h_eff - DIM_W'(1);

  assign col_c = ({1'b0, col_r} >= w_eff) ? w_m1[CNT_W-1:0] : col_r;
  assign row_c = ({1'b0, row_r} >= h_eff) ? h_m1[CNT_W-1:0] : row_r;

  assign ox_full = h_m1 - {1'b0, row_c};
  assign oy_full = flip_r ? (w_m1 - {1'b0, col_c}) : {1'b0, col_c};
  assign last_c  = ({1'b0, col_c} == w_m1) && ({1'b0, row_c} == h_m1);

  assign col_inc = {1'b0, col_c} + DIM_W'(1);
  assign row_inc = {1'b0, row_c} + DIM_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_eff) ? '0 : row_inc[CNT_W-1:0];
      end else begin
        col_nxt = col_inc[CNT_W-1:0];
        row_nxt = row_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Input register stage
  // --------------------------------------------------------------------------
  logic             a_vld_r;
  rgb_pix_t         a_pix_r;
  logic [CNT_W-1:0] a_ox_r, a_oy_r;
  logic             a_last_r;
  logic             out_load;

  assign out_load = !out_valid || !out_stall;
  assign in_stall = a_vld_r && !out_load;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (!in_stall) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_pix_r  <= in_data;
      a_ox_r   <= ox_full[CNT_W-1:0];
      a_oy_r   <= oy_full[CNT_W-1:0];
      a_last_r <= last_c;
    end
  end

  // --------------------------------------------------------------------------
  // Color and addresses, into the result register
  // --------------------------------------------------------------------------
  yuv_t                     yuv;
  logic [CNT_W+DIM_W-1:0]   prod;        // oy * H
  logic                     cv;
  logic [LADDR_W-1:0]       luma_addr;
  logic [CADDR_W-1:0]       chroma_addr;
  nv21_res_t                res_nxt;
  logic                     out_vld_r;
  nv21_res_t                out_data_r;

  rnv21_color u_color (
    .pix (a_pix_r),
    .yuv (yuv)
  );

  assign prod = {{DIM_W{1'b0}}, a_oy_r} * {{CNT_W{1'b0}}, h_eff};
  assign cv   = !a_ox_r[0] && !a_oy_r[0];

  assign luma_addr = prod[LADDR_W-1:0] + {{(LADDR_W-CNT_W){1'b0}}, a_ox_r};
  // oy even whenever chroma is used, so (oy/2)*H equals (oy*H)/2.
  assign chroma_addr = fsize_r + CADDR_W'(prod[CNT_W+DIM_W-1:1])
                     + {{(CADDR_W-CNT_W){1'b0}}, a_ox_r};

  always_comb begin
    res_nxt.luma_address   = luma_addr;
    res_nxt.luma_value     = yuv.y;
    res_nxt.chroma_valid   = cv;
    res_nxt.chroma_address = cv ? chroma_addr : '0;
    res_nxt.v_value        = cv ? yuv.v : 8'd0;
    res_nxt.u_value        = cv ? yuv.u : 8'd0;
    res_nxt.frame_end      = a_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && a_vld_r) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rgb_to_nv21_rotating_converter: drives RGB pixels
// and APB register writes, predicts every luma/chroma result in a scoreboard
// and compares the result stream field by field under random idling.
// ----------------------------------------------------------------------------
module testbench;
  import rnv21_pkg::*;

  // Predicts one NV21 result per accepted pixel from its own copy of the
  // registers and the source column/row counters.
  class nv21_predictor;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             flip_reg;
    int unsigned      column;
    int unsigned      row;
    nv21_res_t        expected_q[$];
    int               mismatches;

    function new();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      flip_reg   = 1'b0;
      column     = 0;
      row        = 0;
      mismatches = 0;
    endfunction

    // dimension as the block uses it: held within [2, MAX_DIM]
    function int unsigned used_dim(logic [DIM_W-1:0] d);
      if (d < 2) return 2;
      if (d > MAX_DIM) return MAX_DIM;
      return d;
    endfunction

    function void set_register(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        REG_WIDTH: begin
          width_reg = data[DIM_W-1:0];
          column = 0;
          row = 0;
        end
        REG_HEIGHT: begin
          height_reg = data[DIM_W-1:0];
          column = 0;
          row = 0;
        end
        REG_FLIP: begin
          flip_reg = data[0];
        end
        default: ;
      endcase
    endfunction

    function void take_pixel(rgb_pix_t px);
      nv21_res_t       e;
      int unsigned     w, h, col, rw, ox, oy;
      int              r, g, b, y, v, u;
      longint unsigned la, ca;
      w = used_dim(width_reg);
      h = used_dim(height_reg);
      r = int'(px.red);
      g = int'(px.green);
      b = int'(px.blue);
      col = (column >= w) ? w - 1 : column;
      rw  = (row >= h) ? h - 1 : row;
      ox = h - 1 - rw;
      oy = flip_reg ? (w - 1 - col) : col;
      y = (r >> 2) + (r >> 7) + (g >> 1) + (g >> 8) + (b >> 4) + (b >> 5) + (b >> 8) + 16;
      v = (r >> 1) - (r >> 4) - (g >> 2) - (g >> 3) + (g >> 7) - (b >> 4) - (b >> 7) + 128;
      u = -(r >> 3) - (r >> 6) - (r >> 7) - (g >> 2) - (g >> 5) - (g >> 7)
          + (b >> 1) - (b >> 4) + 128;
      e = '0;
      la = oy;
      la = la * h + ox;
      e.luma_address = la[LADDR_W-1:0];
      e.luma_value   = y[7:0];
      if (!ox[0] && !oy[0]) begin
        ca = w;
        ca = ca * h + longint'(oy >> 1) * h + ox;
        e.chroma_valid   = 1'b1;
        e.chroma_address = ca[CADDR_W-1:0];
        e.v_value        = v[7:0];
        e.u_value        = u[7:0];
      end
      e.frame_end = (col == w - 1) && (rw == h - 1);
      if (col + 1 >= w) begin
        column = 0;
        row = (rw + 1 >= h) ? 0 : rw + 1;
      end else begin
        column = col + 1;
        row = rw;
      end
      expected_q.push_back(e);
    endfunction

    function void cmp_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        mismatches++;
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void match_result(nv21_res_t act);
      nv21_res_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with no pixel pending, expected none, got 0x%0h", $time, act);
        return;
      end
      e = expected_q.pop_front();
      cmp_field("luma_address", e.luma_address, act.luma_address);
      cmp_field("luma_value", e.luma_value, act.luma_value);
      cmp_field("chroma_valid", e.chroma_valid, act.chroma_valid);
      cmp_field("chroma_address", e.chroma_address, act.chroma_address);
      cmp_field("v_value", e.v_value, act.v_value);
      cmp_field("u_value", e.u_value, act.u_value);
      cmp_field("frame_end", e.frame_end, act.frame_end);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 400000;   // far above the slowest correct run
  localparam int RANDOM_PIXELS = 1200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  rgb_pix_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  nv21_res_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  nv21_predictor sb = new();
  int            cycles = 0;
  int            gap_pct = 0;    // sender: chance of an idle cycle before a request
  int            stall_pct = 0;  // receiver: chance of stalling a cycle

  rgb_to_nv21_rotating_converter i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** rgb_to_nv21_rotating_converter: FAILED **");
      $finish;
    end
  end

  // Result side: values sampled at the edge are the pre-edge ones, so the
  // accept decision matches what the block saw. Stall redrawn every cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.match_result(out_data);
    end
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // One pixel request; returns at the edge where it was taken.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    rgb_pix_t px;
    px = '{red: r, green: g, blue: b};
    while ((gap_pct != 0) && ($urandom_range(0, 99) < gap_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    sb.take_pixel(px);
  endtask

  // APB write: setup phase, then access phase, then idle.
  task automatic apb_write(input cfg_reg_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // Hold off new requests until every expected result is back, plus the
  // two-stage pipeline depth with margin.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Color component, biased toward the extremes.
  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) return 8'h00;
    if (sel < 24) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Dimension register value: mostly small frames so counters wrap often,
  // some out-of-range and full-size ones, sometimes junk in the upper bits.
  function automatic logic [31:0] pick_dim();
    logic [31:0] d;
    int          sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) d = $urandom_range(2, 12);
    else if (sel < 75) d = $urandom_range(0, 1);
    else if (sel < 82) d = MAX_DIM;
    else if (sel < 90) d = $urandom_range(MAX_DIM + 1, 8191);
    else d = $urandom_range(13, MAX_DIM);
    if ($urandom_range(0, 99) < 20) d[31:DIM_W] = (32-DIM_W)'($urandom);
    return d;
  endfunction

  initial begin
    int done;
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // reset geometry 640x480
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h00);
    wait_idle();
    // smallest frame, two full frames so frame_end and wrap are seen
    apb_write(REG_WIDTH, 32'd2);
    apb_write(REG_HEIGHT, 32'd2);
    apb_write(REG_FLIP, 32'd0);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00);
    wait_idle();
    // flip changes mapping without restarting the frame
    apb_write(REG_FLIP, 32'hFFFF_FFFF);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h80, 8'h7F, 8'h01);
    wait_idle();
    // write to an unmapped register: nothing changes
    apb_write(REG_NONE, 32'hFFFF_FFFF);
    send_pixel(8'h01, 8'h80, 8'hFE);
    wait_idle();
    // mid-frame dimension write restarts; odd width, height below minimum
    apb_write(REG_WIDTH, 32'd3);
    apb_write(REG_HEIGHT, 32'd1);
    send_pixel(8'h12, 8'h34, 8'h56);
    send_pixel(8'hFE, 8'h01, 8'h7F);
    send_pixel(8'h7F, 8'hFE, 8'h80);
    wait_idle();
    // width above the maximum, height zero; then full size with flip so the luma
    // address reaches the top of its field
    apb_write(REG_WIDTH, 32'd8191);
    apb_write(REG_HEIGHT, 32'd0);
    send_pixel(8'hFF, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'hFF);
    wait_idle();
    apb_write(REG_WIDTH, MAX_DIM);
    apb_write(REG_HEIGHT, MAX_DIM);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00);
    wait_idle();

    // --- random part: phases of random geometry ---
    done = 0;
    while (done < RANDOM_PIXELS) begin
      // registers only change while the pipeline is empty
      wait_idle();
      if ($urandom_range(0, 99) < 60) apb_write(REG_WIDTH, pick_dim());
      if ($urandom_range(0, 99) < 60) apb_write(REG_HEIGHT, pick_dim());
      if ($urandom_range(0, 99) < 50) apb_write(REG_FLIP, $urandom);
      if ($urandom_range(0, 99) < 10) apb_write(REG_NONE, $urandom);
      n = $urandom_range(20, 120);
      repeat (n) begin
        // receiver-heavy stalling, then sender-heavy idling, then full rate
        gap_pct   = (done < 400) ? 34 : ((done < 800) ? 82 : 0);
        stall_pct = (done < 400) ? 82 : ((done < 800) ? 34 : 0);
        send_pixel(pick_byte(), pick_byte(), pick_byte());
        done++;
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** rgb_to_nv21_rotating_converter: PASSED **");
    end else begin
      $display("** rgb_to_nv21_rotating_converter: FAILED **");
    end
    $finish;
  end

endmodule
